FILE: rtl/sprite_quad_vertex_generator_defines.svh
// assertion macros for the sprite quad vertex generator
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_DEFINES_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SQVG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sqvg assertion failed");
// antecedent implies consequent in the next cycle
`define SQVG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sqvg assertion failed");
`else
`define SQVG_ASSERT_IMPLY(label, ante, cons)
`define SQVG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/sqvg_pkg.sv
// shared constants, types and tables of the sprite quad vertex generator
package sqvg_pkg;
    localparam int COORD_BITS_DEF = 24;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int ORIGIN_W       = 16;
    localparam int ANGLE_W        = 16;
    localparam int TEX_W          = 16;
    localparam int TINT_W         = 32;
    localparam int CS_W           = 17;
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_W       = 34;
    localparam int Z_W            = 32;
    localparam int CORNER_W       = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [CORNER_W-1:0] CORNER_LAST = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [Z_W-1:0] atan_entry(input logic [3:0] idx);
        logic [Z_W-1:0] r;
        case (idx)
            4'd0:    r = 32'h20000000;
            4'd1:    r = 32'h12E4051E;
            4'd2:    r = 32'h09FB385B;
            4'd3:    r = 32'h051111D4;
            4'd4:    r = 32'h028B0D43;
            4'd5:    r = 32'h0145D7E1;
            4'd6:    r = 32'h00A2F61E;
            4'd7:    r = 32'h00517C55;
            4'd8:    r = 32'h0028BE53;
            4'd9:    r = 32'h00145F2F;
            4'd10:   r = 32'h000A2F98;
            4'd11:   r = 32'h000517CC;
            4'd12:   r = 32'h00028BE6;
            4'd13:   r = 32'h000145F3;
            4'd14:   r = 32'h0000A2FA;
            default: r = 32'h0000517D;
        endcase
        return r;
    endfunction
endpackage

FILE: rtl/sqvg_front.sv
// front end: sprite intake, pivot offsets and pipelined cordic sine/cosine
module sqvg_front #(
    parameter int COORD_BITS = sqvg_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = sqvg_pkg::ANGLE_BITS_DEF,
    parameter int IN_W       = 8,
    parameter int ENTRY_W    = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_W-1:0]           s_tdata,
    output logic                      q_push,
    output logic [ENTRY_W-1:0]        q_data,
    input  sqvg_pkg::q_status_t       q_stat
);
    localparam int C      = COORD_BITS;
    localparam int STEPS  = sqvg_pkg::CORDIC_STEPS;
    localparam int PROD_W = C + sqvg_pkg::ORIGIN_W;
    localparam int OX_W   = C + 3;
    localparam int TEX4_W = 4 * sqvg_pkg::TEX_W;
    localparam int PL_W   = 4 * C + 2 * PROD_W + TEX4_W + sqvg_pkg::TINT_W + 3;
    localparam int CW     = sqvg_pkg::CORDIC_W;
    localparam int ZW     = sqvg_pkg::Z_W;

    logic signed [C-1:0]                  px, py, w, h;
    logic signed [sqvg_pkg::ORIGIN_W-1:0] orx, ory;
    logic [sqvg_pkg::ANGLE_W-1:0]         ang;
    logic [TEX4_W-1:0]                    tex;
    logic [sqvg_pkg::TINT_W-1:0]          tint;
    logic signed [PROD_W-1:0]             prodx, prody;
    logic [31:0]                          phase;
    logic                                 advance;

    logic                 valid_reg [0:STEPS];
    logic signed [CW-1:0] x_reg     [0:STEPS];
    logic signed [CW-1:0] y_reg     [0:STEPS];
    logic signed [ZW-1:0] z_reg     [0:STEPS];
    logic [PL_W-1:0]      pl_reg    [0:STEPS];

    assign px   = s_tdata[C-1:0];
    assign py   = s_tdata[2*C-1:C];
    assign w    = s_tdata[3*C-1:2*C];
    assign h    = s_tdata[4*C-1:3*C];
    assign orx  = s_tdata[4*C+15:4*C];
    assign ory  = s_tdata[4*C+31:4*C+16];
    assign ang  = s_tdata[4*C+47:4*C+32];
    assign tex  = s_tdata[4*C+111:4*C+48];
    assign tint = s_tdata[4*C+143:4*C+112];

    assign prodx = PROD_W'(orx) * PROD_W'(w);
    assign prody = PROD_W'(ory) * PROD_W'(h);
    assign phase = 32'(({16'b0, ang} & 32'((64'd1 << ANGLE_BITS) - 64'd1))
                       << (32 - ANGLE_BITS));

    assign advance  = !(valid_reg[STEPS] && q_stat.full);
    assign s_tready = advance;
    assign q_push   = valid_reg[STEPS] && !q_stat.full;

    // valid bits of stage 0 and of every cordic stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            valid_reg[0] <= s_tvalid;
            for (int i = 0; i < STEPS; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    // stage 0 registers the sprite, offset products and phase,
    // then one cordic rotation per stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]  <= sqvg_pkg::CORDIC_GAIN;
            y_reg[0]  <= '0;
            z_reg[0]  <= {2'b00, phase[29:0]};
            pl_reg[0] <= {phase[29:0] == 30'd0, phase[31:30], tint, tex,
                          prody, prodx, h, w, py, px};
            for (int i = 0; i < STEPS; i++)
            begin
                if (z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + signed'(sqvg_pkg::atan_entry(4'(i)));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - signed'(sqvg_pkg::atan_entry(4'(i)));
                end
                pl_reg[i+1] <= pl_reg[i];
            end
        end
    end

    // final rounding, quadrant fold and offset rounding
    logic [PL_W-1:0]           plf;
    logic signed [CW-1:0]      cr, sr;
    logic signed [sqvg_pkg::CS_W-1:0] cb, sb, cq, sq;
    logic signed [PROD_W-1:0]  pfx, pfy, rfx, rfy;
    logic signed [OX_W-1:0]    ox, oy;
    logic [1:0]                quad;
    logic                      zero_rem;

    assign plf      = pl_reg[STEPS];
    assign pfx      = plf[4*C+PROD_W-1:4*C];
    assign pfy      = plf[4*C+2*PROD_W-1:4*C+PROD_W];
    assign quad     = plf[PL_W-2:PL_W-3];
    assign zero_rem = plf[PL_W-1];
    assign cr       = (x_reg[STEPS] + CW'(16384)) >>> 15;
    assign sr       = (y_reg[STEPS] + CW'(16384)) >>> 15;
    assign rfx      = (pfx + PROD_W'(8192)) >>> 14;
    assign rfy      = (pfy + PROD_W'(8192)) >>> 14;
    assign ox       = -OX_W'(rfx);
    assign oy       = -OX_W'(rfy);

    always_comb
    begin
        if (zero_rem)
        begin
            cb = 17'sd32768;
            sb = '0;
        end
        else
        begin
            cb = cr < 0 ? '0 : (cr > CW'(32768) ? 17'sd32768 : sqvg_pkg::CS_W'(cr));
            sb = sr < 0 ? '0 : (sr > CW'(32768) ? 17'sd32768 : sqvg_pkg::CS_W'(sr));
        end
        unique case (quad)
            sqvg_pkg::QUAD_0: begin cq = cb;  sq = sb;  end
            sqvg_pkg::QUAD_1: begin cq = -sb; sq = cb;  end
            sqvg_pkg::QUAD_2: begin cq = -cb; sq = -sb; end
            default:          begin cq = sb;  sq = -cb; end
        endcase
    end

    assign q_data = {plf[4*C+2*PROD_W+TEX4_W+sqvg_pkg::TINT_W-1:4*C+2*PROD_W],
                     sq, cq, oy, ox, plf[4*C-1:0]};
endmodule

FILE: rtl/sqvg_queue.sv
// small queue between the front and back ends
module sqvg_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = sqvg_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [DATA_W-1:0]   push_data,
    input  logic                pop,
    output logic [DATA_W-1:0]   head,
    output sqvg_pkg::q_status_t stat
);
    localparam int PW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [PW-1:0]     wr_reg, rd_reg;
    logic [PW:0]       cnt_reg;

    assign stat.full  = cnt_reg == (PW+1)'(DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign head       = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end
endmodule

FILE: rtl/sqvg_back.sv
// back end: corner walk, rotation, translation and saturation
module sqvg_back #(
    parameter int COORD_BITS = sqvg_pkg::COORD_BITS_DEF,
    parameter int ENTRY_W    = 8,
    parameter int OUT_W      = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ENTRY_W-1:0]  head,
    input  sqvg_pkg::q_status_t q_stat,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic                m_tlast
);
    localparam int C     = COORD_BITS;
    localparam int OX_W  = C + 3;
    localparam int CSW   = sqvg_pkg::CS_W;
    localparam int MUL_W = OX_W + CSW;
    localparam int SUM_W = MUL_W + 1;
    localparam int TW    = sqvg_pkg::TEX_W;

    logic signed [C-1:0]    px, py, w, h;
    logic signed [OX_W-1:0] ox, oy, xs, ys;
    logic signed [CSW-1:0]  c, s;
    logic [4*TW-1:0]        tex;
    logic [sqvg_pkg::TINT_W-1:0] tint;
    logic                   right, bottom, advance, take;

    logic [sqvg_pkg::CORNER_W-1:0] k_reg;

    assign px   = head[C-1:0];
    assign py   = head[2*C-1:C];
    assign w    = head[3*C-1:2*C];
    assign h    = head[4*C-1:3*C];
    assign ox   = head[4*C+OX_W-1:4*C];
    assign oy   = head[4*C+2*OX_W-1:4*C+OX_W];
    assign c    = head[4*C+2*OX_W+CSW-1:4*C+2*OX_W];
    assign s    = head[4*C+2*OX_W+2*CSW-1:4*C+2*OX_W+CSW];
    assign tex  = head[4*C+2*OX_W+2*CSW+4*TW-1:4*C+2*OX_W+2*CSW];
    assign tint = head[ENTRY_W-1:4*C+2*OX_W+2*CSW+4*TW];

    // corners 1 and 2 sit on the right edge, 2 and 3 on the bottom
    assign right   = k_reg[0] ^ k_reg[1];
    assign bottom  = k_reg[1];
    assign xs      = right ? ox + OX_W'(w) : ox;
    assign ys      = bottom ? oy + OX_W'(h) : oy;
    assign advance = !m_tvalid || m_tready;
    assign take    = advance && !q_stat.empty;
    assign q_pop   = take && (k_reg == sqvg_pkg::CORNER_LAST);

    // stage 1: products
    logic                 v1_reg;
    logic signed [MUL_W-1:0] xc_reg, ys_reg, xsn_reg, yc_reg;
    logic signed [C-1:0]  px_reg, py_reg;
    logic [TW-1:0]        u_reg, v_reg;
    logic [sqvg_pkg::TINT_W-1:0] tint_reg;
    logic [sqvg_pkg::CORNER_W-1:0] k1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            k_reg  <= '0;
        end
        else if (advance)
        begin
            v1_reg <= !q_stat.empty;
            if (take)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            xc_reg   <= MUL_W'(xs) * MUL_W'(c);
            ys_reg   <= MUL_W'(ys) * MUL_W'(s);
            xsn_reg  <= MUL_W'(xs) * MUL_W'(s);
            yc_reg   <= MUL_W'(ys) * MUL_W'(c);
            px_reg   <= px;
            py_reg   <= py;
            u_reg    <= right ? tex[3*TW-1:2*TW] : tex[TW-1:0];
            v_reg    <= bottom ? tex[4*TW-1:3*TW] : tex[2*TW-1:TW];
            tint_reg <= tint;
            k1_reg   <= k_reg;
        end
    end

    // stage 2: rotate, translate, saturate into the output register
    logic signed [SUM_W-1:0] rx, ry, fx, fy;
    logic signed [C-1:0]     vx, vy;
    localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] CMIN = -SUM_W'(64'sd1 <<< (C - 1));

    assign rx = (SUM_W'(xc_reg) - SUM_W'(ys_reg) + SUM_W'(16384)) >>> 15;
    assign ry = (SUM_W'(xsn_reg) + SUM_W'(yc_reg) + SUM_W'(16384)) >>> 15;
    assign fx = rx + SUM_W'(px_reg);
    assign fy = ry + SUM_W'(py_reg);
    assign vx = fx > CMAX ? C'(CMAX) : (fx < CMIN ? C'(CMIN) : C'(fx));
    assign vy = fy > CMAX ? C'(CMAX) : (fy < CMIN ? C'(CMIN) : C'(fy));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && v1_reg)
        begin
            m_tdata <= OUT_W'({k1_reg, tint_reg, v_reg, u_reg, vy, vx});
            m_tlast <= k1_reg == sqvg_pkg::CORNER_LAST;
        end
    end
endmodule

FILE: rtl/sprite_quad_vertex_generator.sv
// top level of the sprite quad vertex generator
// Takes one sprite per input transaction and emits its four corner vertices,
// in the order (u0,v0), (u1,v0), (u1,v1), (u0,v1), as four output
// transactions, the fourth marked by m_tlast. Each corner is offset by
// -origin*size, rotated by the binary angle and moved to the position, with
// coordinates saturated to COORD_BITS. The single output port carries one
// vertex per cycle while m_tready is high and the queue holds a sprite; the
// front end can take a sprite every cycle unless a finished sprite waits on
// a full queue, and runs ahead into a four-entry queue. On its way to the
// first vertex a sprite passes the cordic pipeline, the queue and two back-end stages.
// There is no configuration and no clearing pass after reset.
`include "sprite_quad_vertex_generator_defines.svh"
module sprite_quad_vertex_generator #(
    parameter int COORD_BITS = sqvg_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = sqvg_pkg::ANGLE_BITS_DEF,
    localparam int IN_W  = ((4 * COORD_BITS + 144 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 66 + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // pos_x, pos_y, width, height, origin_x, origin_y, angle,
    // tex_u0, tex_v0, tex_u1, tex_v1, tint_rgba
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // vert_x, vert_y, vert_u, vert_v, vert_tint, corner
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);
    localparam int ENTRY_W   = 6 * COORD_BITS + 6 + 2 * sqvg_pkg::CS_W + 96;
    localparam int CORNER_LO = 2 * COORD_BITS + 64;

    logic                q_push, q_pop;
    logic [ENTRY_W-1:0]  q_wdata, q_head;
    sqvg_pkg::q_status_t q_stat;

    // sprite intake, offsets and sine/cosine
    sqvg_front #(
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS),
        .IN_W       (IN_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_stat   (q_stat)
    );

    // decouples the cordic pipeline from the vertex walk
    sqvg_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (sqvg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // four vertices per queued sprite
    sqvg_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_W    (ENTRY_W),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // queue never overflows or underflows
    `SQVG_ASSERT_IMPLY(a_no_overflow, q_push, !q_stat.full)
    `SQVG_ASSERT_IMPLY(a_no_underflow, q_pop, !q_stat.empty)
    // tlast marks exactly the fourth corner
    `SQVG_ASSERT_IMPLY(a_last_corner, m_tvalid,
        m_tlast == (m_tdata[CORNER_LO+1:CORNER_LO] == sqvg_pkg::CORNER_LAST))
    // after a last vertex leaves with the queue empty, the next vertex is not a fourth corner
    `SQVG_ASSERT_NEXT(a_corner_wrap, m_tvalid && m_tready && m_tlast && q_stat.empty,
        !m_tvalid || m_tdata[CORNER_LO+1:CORNER_LO] != sqvg_pkg::CORNER_LAST)
endmodule
